// ===== rtl/dnsd_pkg.sv =====
// Shared types, constants and helpers of the DNS name decompressor.
package dnsd_pkg;

  localparam int STORE_BYTES = 512;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int POS_W       = $clog2(STORE_BYTES + 257);
  localparam int OFF_W       = 14;
  localparam int CMP_W       = (POS_W > OFF_W) ? POS_W : OFF_W;
  localparam int CLR_W       = ADDR_W + 1;

  localparam logic [2:0] JUMP_LIMIT = 3'd5;
  localparam logic [1:0] PTR_MARK   = 2'b11;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [8:0] LIMIT_RST  = 9'd256;
  localparam logic [8:0] LIMIT_MAX  = 9'd256;
  localparam logic [2:0] PADDR_NAME_LIMIT = 3'd0;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PAST    = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_FORWARD = 3'd3;
  localparam logic [2:0] ST_JUMPS   = 3'd4;

  typedef struct packed {
    logic       func;
    logic [8:0] address;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] name_chars;
    logic [3:0]  char_count;
    logic        last;
    logic [2:0]  status;
    logic [9:0]  next_pos;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

endpackage

// ===== rtl/dnsd_ram.sv =====
// Generic single-port RAM with registered read.
module dnsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/dnsd_cfg.sv =====
// APB register block holding name_limit and the derived character capacity.
module dnsd_cfg import dnsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  cap
);

  logic [8:0] limit_r, limit_nxt;
  logic [8:0] lim;

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && paddr == PADDR_NAME_LIMIT) begin
      limit_nxt = pwdata[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  always_comb begin
    priority if (limit_r == 9'd0) begin
      lim = 9'd1;
    end else if (limit_r > LIMIT_MAX) begin
      lim = LIMIT_MAX;
    end else begin
      lim = limit_r;
    end
  end

  assign cap    = 8'(lim - 9'd1);
  assign pready = 1'b1;
  assign prdata = (paddr == PADDR_NAME_LIMIT) ? {23'd0, limit_r} : 32'd0;

endmodule

// ===== rtl/dnsd_walker.sv =====
// Sequencer: store clear, writes, label and pointer walk, result packing.
module dnsd_walker import dnsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [7:0] cap,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  output mem_req_t  mem_req,
  input  logic [7:0] mem_rdata
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LEN   = 7'b0000100,
    S_PTR   = 7'b0001000,
    S_CHAR  = 7'b0010000,
    S_PUT   = 7'b0100000,
    S_LAST  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, cp_r, cp_nxt, end_r, end_nxt;
  logic [POS_W-1:0] ret_r, ret_nxt, next_r, next_nxt;
  logic [5:0]       len_r, len_nxt;
  logic [7:0]       n_r, n_nxt, ch_r, ch_nxt;
  logic [2:0]       jumps_r, jumps_nxt, status_r, status_nxt;
  logic             jumped_r, jumped_nxt;
  logic [63:0]      word_r, word_nxt;
  logic [3:0]       wcnt_r, wcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             out_free, emit, go_len, fin, do_step;
  out_item_t        emit_item;
  logic [POS_W-1:0] lenpos, fin_next, step_cp, pos_inc;
  logic [2:0]       fin_status;
  logic [7:0]       step_n;
  logic [OFF_W-1:0] off;

  assign out_free = !out_valid_r || out_ready;
  assign pos_inc  = pos_r + POS_W'(1);
  assign off      = {len_r, mem_rdata};

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    pos_nxt    = pos_r;
    cp_nxt     = cp_r;
    end_nxt    = end_r;
    ret_nxt    = ret_r;
    next_nxt   = next_r;
    len_nxt    = len_r;
    n_nxt      = n_r;
    ch_nxt     = ch_r;
    jumps_nxt  = jumps_r;
    status_nxt = status_r;
    jumped_nxt = jumped_r;
    word_nxt   = word_r;
    wcnt_nxt   = wcnt_r;
    mem_req    = '0;
    emit       = 1'b0;
    emit_item  = '0;
    go_len     = 1'b0;
    lenpos     = '0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_next   = '0;
    do_step    = 1'b0;
    step_n     = n_r;
    step_cp    = cp_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r[ADDR_W-1:0];
        clr_nxt      = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_WRITE) begin
            if (32'(in_data.address) < STORE_BYTES) begin
              mem_req.we    = 1'b1;
              mem_req.addr  = ADDR_W'(in_data.address);
              mem_req.wdata = in_data.data_byte;
            end
          end else begin
            n_nxt      = '0;
            jumps_nxt  = '0;
            jumped_nxt = 1'b0;
            ret_nxt    = '0;
            word_nxt   = '0;
            wcnt_nxt   = '0;
            go_len     = 1'b1;
            lenpos     = POS_W'(in_data.address);
          end
        end
      end
      S_LEN: begin
        if (mem_rdata[7:6] == PTR_MARK) begin
          len_nxt = mem_rdata[5:0];
          if (32'(pos_inc) >= STORE_BYTES) begin
            fin        = 1'b1;
            fin_status = ST_PAST;
          end else begin
            mem_req.addr = ADDR_W'(pos_inc);
            state_nxt    = S_PTR;
          end
        end else begin
          pos_nxt = pos_inc;
          if (mem_rdata == 8'd0) begin
            fin      = 1'b1;
            fin_next = jumped_r ? ret_r : pos_inc;
          end else begin
            end_nxt = pos_inc + POS_W'(mem_rdata);
            cp_nxt  = pos_inc;
            if (n_r != 8'd0 && n_r < cap) begin
              ch_nxt    = DOT_CHAR;
              state_nxt = S_PUT;
            end else begin
              do_step = 1'b1;
              step_cp = pos_inc;
            end
          end
        end
      end
      S_PTR: begin
        if (32'(off) >= STORE_BYTES) begin
          fin        = 1'b1;
          fin_status = ST_OUTSIDE;
        end else if (CMP_W'(off) >= CMP_W'(pos_r)) begin
          fin        = 1'b1;
          fin_status = ST_FORWARD;
        end else begin
          if (!jumped_r) begin
            ret_nxt = pos_r + POS_W'(2);
          end
          jumped_nxt = 1'b1;
          jumps_nxt  = jumps_r + 3'd1;
          go_len     = 1'b1;
          lenpos     = POS_W'(off);
        end
      end
      S_CHAR: begin
        ch_nxt    = fold(mem_rdata);
        cp_nxt    = cp_r + POS_W'(1);
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (wcnt_r == 4'd8) begin
          if (out_free) begin
            emit                 = 1'b1;
            emit_item.name_chars = word_r;
            emit_item.char_count = wcnt_r;
            word_nxt             = {56'd0, ch_r};
            wcnt_nxt             = 4'd1;
            n_nxt                = n_r + 8'd1;
            do_step              = 1'b1;
            step_n               = n_r + 8'd1;
          end
        end else begin
          word_nxt[wcnt_r[2:0]*8 +: 8] = ch_r;
          wcnt_nxt = wcnt_r + 4'd1;
          n_nxt    = n_r + 8'd1;
          do_step  = 1'b1;
          step_n   = n_r + 8'd1;
        end
      end
      S_LAST: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_item.name_chars = word_r;
          emit_item.char_count = wcnt_r;
          emit_item.last       = 1'b1;
          emit_item.status     = status_r;
          emit_item.next_pos   = 10'(next_r);
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_step) begin
      priority if (step_cp >= end_nxt || step_n >= cap) begin
        go_len = 1'b1;
        lenpos = end_nxt;
      end else if (32'(step_cp) >= STORE_BYTES) begin
        fin        = 1'b1;
        fin_status = ST_PAST;
      end else begin
        mem_req.addr = ADDR_W'(step_cp);
        state_nxt    = S_CHAR;
      end
    end

    if (go_len) begin
      priority if (jumps_nxt > JUMP_LIMIT) begin
        fin        = 1'b1;
        fin_status = ST_JUMPS;
      end else if (32'(lenpos) >= STORE_BYTES) begin
        fin        = 1'b1;
        fin_status = ST_PAST;
      end else begin
        mem_req.addr = ADDR_W'(lenpos);
        pos_nxt      = lenpos;
        state_nxt    = S_LEN;
      end
    end

    if (fin) begin
      status_nxt = fin_status;
      next_nxt   = (fin_status == ST_OK) ? fin_next : '0;
      state_nxt  = S_LAST;
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cp_r     <= cp_nxt;
    end_r    <= end_nxt;
    ret_r    <= ret_nxt;
    next_r   <= next_nxt;
    len_r    <= len_nxt;
    n_r      <= n_nxt;
    ch_r     <= ch_nxt;
    jumps_r  <= jumps_nxt;
    status_r <= status_nxt;
    jumped_r <= jumped_nxt;
    word_r   <= word_nxt;
    wcnt_r   <= wcnt_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during store clear");

  a_err_no_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last && out_r.status != ST_OK) |-> (out_r.next_pos == 10'd0))
    else $error("error result carries a next position");

  a_full_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> (out_r.char_count == 4'd8))
    else $error("non-final result not full");

  a_jumps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEN) |-> (jumps_r <= JUMP_LIMIT))
    else $error("walk went on past the jump limit");

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST) |-> (n_r <= cap))
    else $error("more characters than capacity");

endmodule

// ===== rtl/dns_name_decompressor_core.sv =====
// Top level of the DNS name decompressor: store RAM, register block, sequencer.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): func 0 writes data_byte at
//   address into the 512-byte packet store (no result); func 1 decodes the
//   name starting at address.
//   Result channel (out_valid/out_ready/out_data): a decode yields one
//   transfer per eight characters, at least one; the final transfer has
//   last set and carries status and next_pos.
//   APB port: register name_limit at byte address 0, reset 256.
//   Reset clears the store in a pass that writes one byte per cycle;
//   in_ready stays low until it ends.
//   A write is done in the idle state. A decode has an accept step, a read
//   per length byte, two reads per pointer, a read and a placing step per
//   character, a placing step per dot, and a final state that loads the
//   last result; each read goes through the single-port store's registered read.
//   One item is processed at a time. A stalled receiver holds the result
//   register; the walk continues until the next result must be placed.
module dns_name_decompressor_core import dnsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic [7:0] cap;

  dnsd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  dnsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  dnsd_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the DNS name decompressor core.
module tb_top;
  import dnsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dns_name_decompressor_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  items_to_send[$];
  out_item_t words_due[$];
  out_item_t want;
  logic [7:0] store_img [0:STORE_BYTES-1];
  int   limit_reg = LIMIT_RST;
  int   name_heads[$];
  int   errors = 0;
  int   queued_items = 0;
  int   n_writes = 0, n_decodes = 0, n_words = 0, n_cfg = 0;
  int   st_seen [0:4];
  int   idle_pct = 20;
  bit   long_hold_req = 1'b0;
  bit   long_hold_done = 1'b0;
  int   tx_gap = 0;
  int   rx_hold = 0;

  // Mirror a write into the store image, or walk the name in the mirrored store and queue the result words it yields.
  task automatic walk_name(input in_item_t it);
    logic [7:0] chr [0:255];
    int cap, n, pos, jumps, nxt, ret_pos, off, i, k, j, nres, cnt;
    logic [2:0] st;
    logic [7:0] len, c;
    bit jumped, done;
    out_item_t r;
    if (it.func == FUNC_WRITE) begin
      store_img[it.address] = it.data_byte;
      n_writes++;
      return;
    end
    n_decodes++;
    cap = limit_reg;
    if (cap < 1) cap = 1;
    if (cap > LIMIT_MAX) cap = LIMIT_MAX;
    cap--;
    pos = int'(it.address);
    n = 0; jumps = 0; nxt = 0; ret_pos = 0; jumped = 0; done = 0;
    st = ST_OK;
    while (!done) begin
      if (jumps > JUMP_LIMIT) begin
        st = ST_JUMPS;
        done = 1;
      end else if (pos >= STORE_BYTES) begin
        st = ST_PAST;
        done = 1;
      end else begin
        len = store_img[pos];
        if (len[7:6] == PTR_MARK) begin
          if (pos + 1 >= STORE_BYTES) begin
            st = ST_PAST;
            done = 1;
          end else begin
            off = int'({len[5:0], store_img[pos+1]});
            if (off >= STORE_BYTES) begin
              st = ST_OUTSIDE;
              done = 1;
            end else if (off >= pos) begin
              st = ST_FORWARD;
              done = 1;
            end else begin
              if (!jumped) ret_pos = pos + 2;
              jumped = 1;
              pos = off;
              jumps++;
            end
          end
        end else begin
          pos++;
          if (len == 8'h00) begin
            nxt = jumped ? ret_pos : pos;
            done = 1;
          end else begin
            if (n != 0 && n < cap) begin
              chr[n] = DOT_CHAR;
              n++;
            end
            // label bytes past the limit are skipped unread
            for (i = 0; i < len && n < cap && st == ST_OK; i++) begin
              if (pos + i >= STORE_BYTES) begin
                st = ST_PAST;
              end else begin
                c = store_img[pos+i];
                if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
                chr[n] = c;
                n++;
              end
            end
            if (st != ST_OK) done = 1;
            else pos += len;
          end
        end
      end
    end
    if (st != ST_OK) nxt = 0;
    st_seen[st]++;
    nres = (n + 7) / 8;
    if (nres == 0) nres = 1;
    for (k = 0; k < nres; k++) begin
      r = '0;
      cnt = 0;
      for (j = 0; j < 8 && k * 8 + j < n; j++) begin
        r.name_chars[8*j +: 8] = chr[k*8+j];
        cnt++;
      end
      r.char_count = cnt[3:0];
      if (k == nres - 1) begin
        r.last = 1'b1;
        r.status = st;
        r.next_pos = nxt[9:0];
      end
      words_due.push_back(r);
    end
  endtask

  function automatic int field_bad(input string f, input logic [63:0] e, input logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, f, e, a);
      return 1;
    end
    return 0;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0 && idle_pct != 0 &&
                   $urandom_range(0, 99) < idle_pct) begin
        tx_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= items_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      rx_hold <= 300;
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      rx_hold <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) walk_name(in_data);
      if (out_valid && out_ready) begin
        n_words++;
        if (words_due.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          want = words_due.pop_front();
          errors += field_bad("name_chars", want.name_chars, out_data.name_chars);
          errors += field_bad("char_count", 64'(want.char_count), 64'(out_data.char_count));
          errors += field_bad("last", 64'(want.last), 64'(out_data.last));
          errors += field_bad("status", 64'(want.status), 64'(out_data.status));
          errors += field_bad("next_pos", 64'(want.next_pos), 64'(out_data.next_pos));
        end
      end
    end
  end

  task automatic q_write(input int a, input int b);
    in_item_t it;
    it.func = FUNC_WRITE;
    it.address = a[8:0];
    it.data_byte = b[7:0];
    items_to_send.push_back(it);
    queued_items++;
  endtask

  task automatic q_decode(input int a);
    in_item_t it;
    it.func = FUNC_DECODE;
    it.address = a[8:0];
    it.data_byte = 8'($urandom_range(0, 255));
    items_to_send.push_back(it);
    queued_items++;
  endtask

  task automatic settle();
    while (items_to_send.size() != 0 || in_valid || words_due.size() != 0)
      @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_limit(input int v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_NAME_LIMIT;
    pwdata <= v & 32'h1FF;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = v & 32'h1FF;
    n_cfg++;
    @(negedge clk);
  endtask

  function automatic int earlier_head(input int lim);
    int cands[$];
    foreach (name_heads[i])
      if (name_heads[i] < lim) cands.push_back(name_heads[i]);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  function automatic int pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(8'h41, 8'h5A);
    if (r < 7) return $urandom_range(8'h61, 8'h7A);
    return $urandom_range(0, 255);
  endfunction

  // mostly well-formed name: labels, then a zero byte or a backward pointer
  task automatic gen_name();
    int base, p, nlab, l, len, k, tgt, r;
    base = ($urandom_range(0, 9) == 0) ? $urandom_range(440, 511) : $urandom_range(0, 420);
    p = base;
    nlab = $urandom_range(1, 3);
    for (l = 0; l < nlab && p <= 511; l++) begin
      r = $urandom_range(0, 19);
      if (r < 16) len = $urandom_range(1, 8);
      else if (r < 18) len = $urandom_range(0, 63);
      else len = $urandom_range(8'h40, 8'hBF);
      q_write(p, len);
      p++;
      for (k = 0; k < len && k < 8 && p <= 511; k++) begin
        q_write(p, pick_char());
        p++;
      end
      p = base + (p - base) + ((len > 8) ? len - 8 : 0);
    end
    if (p <= 510) begin
      tgt = earlier_head(p);
      if (tgt >= 0 && $urandom_range(0, 1) == 1) begin
        q_write(p, 8'hC0 | (tgt >> 8));
        q_write(p + 1, tgt & 8'hFF);
      end else begin
        q_write(p, 0);
      end
    end else if (p == 511) begin
      q_write(p, 0);
    end
    name_heads.push_back(base);
    q_decode(base);
    if ($urandom_range(0, 2) == 0) q_decode($urandom_range(base, (p > 511) ? 511 : p));
  endtask

  // pointer chain of 4..7 hops ending on an earlier name or, if there is none, an earlier byte
  task automatic gen_chain();
    int base, hops, h, tgt;
    base = $urandom_range(20, 490);
    hops = $urandom_range(4, 7);
    tgt = earlier_head(base);
    if (tgt < 0) tgt = $urandom_range(0, base - 1);
    for (h = 0; h < hops && base + 2 * h + 1 <= 511; h++) begin
      q_write(base + 2 * h, 8'hC0 | (tgt >> 8));
      q_write(base + 2 * h + 1, tgt & 8'hFF);
      tgt = base + 2 * h;
    end
    q_decode(tgt);
  endtask

  task automatic gen_bad_ptr();
    int p, off;
    p = $urandom_range(0, 510);
    if ($urandom_range(0, 1) == 1) begin
      off = $urandom_range(p, 511);
      q_write(p, 8'hC0 | (off >> 8));
      q_write(p + 1, off & 8'hFF);
    end else begin
      q_write(p, $urandom_range(8'hC2, 8'hFF));
      q_write(p + 1, $urandom_range(0, 255));
    end
    q_decode(p);
  endtask

  task automatic gen_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) gen_name();
    else if (r < 65) gen_chain();
    else if (r < 73) gen_bad_ptr();
    else if (r < 87) q_write($urandom_range(0, 511), $urandom_range(0, 255));
    else q_decode($urandom_range(0, 511));
  endtask

  int limits [0:7];
  int idles [0:7];
  int ph, budget;

  initial begin
    foreach (store_img[i]) store_img[i] = 8'h00;
    foreach (st_seen[i]) st_seen[i] = 0;
    limits = '{1, 0, 511, 256, 3, 9, 17, 0};
    limits[7] = $urandom_range(1, 511);
    idles = '{15, 40, 0, 20, 0, 40, 15, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    // empty store, then folding edges, pointer cases and store-end reads
    q_decode(0);
    q_decode(511);
    q_write(0, 8'h04);
    q_write(1, 8'h40);
    q_write(2, 8'h41);
    q_write(3, 8'h5A);
    q_write(4, 8'h5B);
    q_write(5, 8'h00);
    q_decode(0);
    q_write(6, 8'h01);
    q_write(7, 8'hFF);
    q_write(8, 8'hC0);
    q_write(9, 8'h00);
    q_decode(6);
    q_write(10, 8'hC0);
    q_write(11, 8'h20);
    q_decode(10);
    q_write(12, 8'hFF);
    q_write(13, 8'hFF);
    q_decode(12);
    q_write(511, 8'hC1);
    q_decode(511);
    q_write(508, 8'h05);
    q_write(509, 8'h51);
    q_write(510, 8'h52);
    q_decode(508);
    name_heads.push_back(0);
    name_heads.push_back(6);
    settle();

    for (ph = 0; ph < 8; ph++) begin
      set_limit(limits[ph]);
      idle_pct = idles[ph];
      if (ph == 2) long_hold_req = 1'b1;
      budget = queued_items + 34;
      while (queued_items < budget) gen_random();
      settle();
    end
    repeat (40) @(negedge clk);
    if (words_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, words_due.size());
      errors++;
    end

    $display("covered %0d store writes and %0d decodes over %0d limit settings, %0d words",
             n_writes, n_decodes, n_cfg, n_words);
    $display("decode endings: ok %0d, past end %0d, ptr outside %0d, ptr forward %0d, jumps %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout at %0t", $time);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dnsd_pkg.sv
rtl/dnsd_ram.sv
rtl/dnsd_cfg.sv
rtl/dnsd_walker.sv
rtl/dns_name_decompressor_core.sv
tb/sv/tb_top.sv
